@@ hw/rtl/pfs_pkg.sv @@
`timescale 1ns / 1ps
package pfs_pkg;

    localparam int TimeBits = 32;
    localparam int NumCh    = 9;
    localparam int ChBits   = 4;

    // configuration register indexes
    localparam logic [2:0] REG_ENABLE  = 3'd0;
    localparam logic [2:0] REG_WEIGHTS = 3'd1;
    localparam logic [2:0] REG_STALE_L = 3'd2;
    localparam logic [2:0] REG_STALE_M = 3'd3;
    localparam logic [2:0] REG_STALE_H = 3'd4;
    localparam logic [2:0] REG_SCORE   = 3'd5;
    localparam logic [2:0] REG_TIMER   = 3'd6;

    // vote codes
    localparam logic [1:0] VOTE_NONE   = 2'd0;
    localparam logic [1:0] VOTE_WEAK   = 2'd1;
    localparam logic [1:0] VOTE_STRONG = 2'd2;
    localparam logic [1:0] VOTE_DENIED = 2'd3;

    // reported levels
    localparam logic [2:0] LVL_LOITER  = 3'd4;
    localparam logic [2:0] LVL_ANOMALY = 3'd5;

    typedef struct packed {
        logic        mode;
        logic [3:0]  channel;
        logic [1:0]  vote;
        logic [7:0]  quality;
        logic [31:0] now_ms;
    } pfs_in_t;

    typedef struct packed {
        logic [2:0] result_level;
        logic       level_changed;
        logic [6:0] confidence;
        logic [6:0] anomaly_level;
        logic [5:0] modality_mask;
        logic [2:0] strong_count;
        logic       denied_seen;
    } pfs_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACC,
        ST_SCORE,
        ST_DECIDE,
        ST_OUT
    } pfs_state_t;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       observe;
        logic       clear_acc;
        logic       scan;
        logic [3:0] ch;
        logic       acc;
        logic       score;
        logic       decide;
    } pfs_cmd_t;

    function automatic logic [2:0] chan_mod(input logic [3:0] ch);
        logic [2:0] m;
        begin
            case (ch)
                4'd0:    m = 3'd0;
                4'd1:    m = 3'd1;
                4'd2:    m = 3'd2;
                4'd3,
                4'd4:    m = 3'd3;
                4'd5,
                4'd6:    m = 3'd4;
                default: m = 3'd5;
            endcase
            return m;
        end
    endfunction

    function automatic logic [2:0] pop6(input logic [5:0] x);
        logic [2:0] n;
        begin
            n = 3'd0;
            for (int i = 0; i < 6; i++)
            begin
                n = n + {2'd0, x[i]};
            end
            return n;
        end
    endfunction

endpackage

@@ hw/rtl/pfs_ctrl.sv @@
`timescale 1ns / 1ps
module pfs_ctrl
    import pfs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_fire,
    input  logic     in_mode,
    input  logic     out_busy,
    output logic     in_ready,
    output logic     out_load,
    output pfs_cmd_t cmd
);

    pfs_state_t state_reg, state_next;
    logic [3:0] ch_reg, ch_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        cmd        = '0;
        cmd.ch     = ch_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_fire;
                if (in_fire)
                begin
                    if (in_mode)
                    begin
                        cmd.clear_acc = 1'b1;
                        ch_next       = 4'd0;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        cmd.observe = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (ch_reg == 4'(NumCh - 1))
                begin
                    state_next = ST_SCORE;
                end
                else
                begin
                    ch_next    = ch_reg + 4'd1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCORE:
            begin
                cmd.score  = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_busy)
                begin
                    cmd.decide = 1'b1;
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

@@ hw/rtl/pfs_datapath.sv @@
`timescale 1ns / 1ps
module pfs_datapath
    import pfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pfs_in_t     in_item,
    input  pfs_cmd_t    cmd,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output pfs_out_t    result
);

    localparam logic [TimeBits-1:0] TZero = '0;

    // configuration
    logic [8:0]  enable_reg;
    logic [62:0] weights_reg;
    logic [47:0] stale_l_reg, stale_m_reg, stale_h_reg;
    logic [45:0] score_reg;
    logic [63:0] timer_reg;

    // channel slots
    logic [1:0]          slot_vote_reg [NumCh];
    logic [6:0]          slot_qual_reg [NumCh];
    logic [TimeBits-1:0] slot_time_reg [NumCh];
    logic [NumCh-1:0]    slot_seen_reg;

    // latched item
    logic [TimeBits-1:0] now_reg;

    // scan pipeline
    logic [1:0]  sv_reg;
    logic [13:0] prod_reg;
    logic [2:0]  sm_reg;
    logic [10:0] evid_reg;
    logic [5:0]  weak_reg, strong_reg;
    logic [3:0]  denied_reg;
    logic        body_reg;

    // score results
    logic [6:0]  conf_reg, anom_reg;
    logic [2:0]  sn_reg;
    logic        silent_reg, anom_hit_reg;
    logic [1:0]  raw_reg;

    // presence state
    logic [1:0]          comm_reg, cand_reg;
    logic [TimeBits-1:0] cand_start_reg, dwell_reg, hold_reg;
    logic [2:0]          last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= '0;
            weights_reg <= '0;
            stale_l_reg <= '0;
            stale_m_reg <= '0;
            stale_h_reg <= '0;
            score_reg   <= '0;
            timer_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE:  enable_reg  <= cfg_data[8:0];
                REG_WEIGHTS: weights_reg <= cfg_data[62:0];
                REG_STALE_L: stale_l_reg <= cfg_data[47:0];
                REG_STALE_M: stale_m_reg <= cfg_data[47:0];
                REG_STALE_H: stale_h_reg <= cfg_data[47:0];
                REG_SCORE:   score_reg   <= cfg_data[45:0];
                REG_TIMER:   timer_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // observe writes
    logic [3:0] in_ch;
    assign in_ch = in_item.channel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_seen_reg <= '0;
            for (int i = 0; i < NumCh; i++)
            begin
                slot_vote_reg[i] <= VOTE_NONE;
                slot_qual_reg[i] <= '0;
                slot_time_reg[i] <= '0;
            end
        end
        else if (cmd.observe && in_ch < 4'(NumCh) && enable_reg[in_ch])
        begin
            slot_vote_reg[in_ch] <= in_item.vote;
            slot_qual_reg[in_ch] <= (in_item.quality > 8'd100) ? 7'd100
                                                              : in_item.quality[6:0];
            slot_time_reg[in_ch] <= in_item.now_ms[TimeBits-1:0];
            slot_seen_reg[in_ch] <= 1'b1;
        end
    end

    // per-channel view
    logic [15:0]         lim;
    logic [47:0]         grp;
    logic [TimeBits-1:0] age;
    logic [1:0]          v_eff;
    logic [6:0]          w;
    logic [3:0]          sc;

    assign sc = cmd.ch;

    always_comb
    begin
        if (sc < 4'd3)      grp = stale_l_reg;
        else if (sc < 4'd6) grp = stale_m_reg;
        else                grp = stale_h_reg;
        case (sc)
            4'd0, 4'd3, 4'd6: lim = grp[15:0];
            4'd1, 4'd4, 4'd7: lim = grp[31:16];
            default:          lim = grp[47:32];
        endcase
        age   = now_reg - slot_time_reg[sc];
        v_eff = slot_vote_reg[sc];
        if (!enable_reg[sc] || !slot_seen_reg[sc] || age > TimeBits'(lim))
        begin
            v_eff = VOTE_NONE;
        end
        w = weights_reg[7*sc +: 7];
    end

    // evidence term: strong /100, weak /200 via reciprocal then fixup
    logic [13:0] div_d;
    logic [27:0] q_est;
    logic [6:0]  q;
    logic [13:0] rem;

    always_comb
    begin
        div_d = (sv_reg == VOTE_STRONG) ? 14'd100 : 14'd200;
        q_est = (sv_reg == VOTE_STRONG) ? 28'(prod_reg) * 28'd5243 >> 19
                                        : 28'(prod_reg) * 28'd5243 >> 20;
        q     = q_est[6:0];
        rem   = prod_reg - 14'(q * div_d);
        if (rem >= div_d)
        begin
            q = q + 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg <= in_item.now_ms[TimeBits-1:0];
        end
        if (cmd.scan)
        begin
            sv_reg   <= v_eff;
            prod_reg <= w * slot_qual_reg[sc];
            sm_reg   <= chan_mod(sc);
        end
        if (cmd.clear_acc)
        begin
            evid_reg   <= '0;
            weak_reg   <= '0;
            strong_reg <= '0;
            denied_reg <= '0;
            body_reg   <= 1'b0;
        end
        else if (cmd.acc)
        begin
            if (sv_reg == VOTE_STRONG || sv_reg == VOTE_WEAK)
            begin
                evid_reg           <= evid_reg + 11'(q);
                weak_reg[sm_reg]   <= 1'b1;
            end
            if (sv_reg == VOTE_STRONG)
            begin
                strong_reg[sm_reg] <= 1'b1;
                if (sm_reg == 3'd1 || sm_reg == 3'd2)
                begin
                    body_reg <= 1'b1;
                end
            end
            if (sv_reg == VOTE_DENIED)
            begin
                denied_reg <= denied_reg + 4'd1;
            end
        end
    end

    // scoring
    logic [2:0]  sn;
    logic [9:0]  bonus;
    logic [10:0] anomaly, csum;
    logic [6:0]  conf, anom;
    logic [1:0]  raw;

    always_comb
    begin
        sn      = pop6(strong_reg);
        bonus   = (sn >= 3'd2) ? 10'(score_reg[37:31]) * 10'(sn - 3'd1) : 10'd0;
        anomaly = 11'(denied_reg) * 11'(score_reg[44:38]);
        if (denied_reg != 4'd0 && body_reg)
        begin
            anomaly = anomaly + 11'(score_reg[44:38]);
        end
        csum = evid_reg + 11'(bonus);
        conf = (csum > 11'd100) ? 7'd100 : csum[6:0];
        anom = (anomaly > 11'd100) ? 7'd100 : anomaly[6:0];
        if (conf >= score_reg[6:0] && sn >= score_reg[30:28]) raw = 2'd3;
        else if (conf >= score_reg[13:7])                     raw = 2'd2;
        else if (conf >= score_reg[20:14])                    raw = 2'd1;
        else                                                  raw = 2'd0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.score)
        begin
            conf_reg     <= conf;
            anom_reg     <= anom;
            sn_reg       <= sn;
            raw_reg      <= raw;
            anom_hit_reg <= anom >= score_reg[27:21];
            silent_reg   <= score_reg[45] && body_reg && sn == 3'd1
                            && pop6(weak_reg) == 3'd1;
        end
    end

    // debounce, dwell and anomaly latch
    logic [1:0]          comm_n, cand_n;
    logic [TimeBits-1:0] cs_n, dw_n, hold_n, need;
    logic [2:0]          rep;

    always_comb
    begin
        comm_n = comm_reg;
        cand_n = cand_reg;
        cs_n   = cand_start_reg;
        dw_n   = dwell_reg;
        hold_n = hold_reg;
        need   = '0;
        if (raw_reg == comm_reg)
        begin
            cand_n = comm_reg;
            cs_n   = now_reg;
        end
        else
        begin
            if (raw_reg != cand_reg)
            begin
                cand_n = raw_reg;
                cs_n   = now_reg;
            end
            need = (raw_reg > comm_reg) ? TimeBits'(timer_reg[15:0])
                                        : TimeBits'(timer_reg[31:16]);
            if (now_reg - cs_n >= need)
            begin
                if (raw_reg >= 2'd2 && comm_reg < 2'd2)
                begin
                    dw_n = now_reg;
                end
                comm_n = raw_reg;
            end
        end
        if (comm_n < 2'd2)
        begin
            dw_n = TZero;
        end
        rep = {1'b0, comm_n};
        if (comm_n >= 2'd2 && now_reg - dw_n >= TimeBits'(timer_reg[47:32]))
        begin
            rep = silent_reg ? LVL_ANOMALY : LVL_LOITER;
        end
        if (anom_hit_reg)
        begin
            rep    = LVL_ANOMALY;
            hold_n = now_reg + TimeBits'(timer_reg[63:48]);
        end
        else if (now_reg < hold_reg)
        begin
            rep = LVL_ANOMALY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comm_reg       <= '0;
            cand_reg       <= '0;
            cand_start_reg <= '0;
            dwell_reg      <= '0;
            hold_reg       <= '0;
            last_reg       <= '0;
        end
        else if (cmd.decide)
        begin
            comm_reg       <= comm_n;
            cand_reg       <= cand_n;
            cand_start_reg <= cs_n;
            dwell_reg      <= dw_n;
            hold_reg       <= hold_n;
            last_reg       <= rep;
        end
    end

    // result assembly
    always_comb
    begin
        result.result_level  = rep;
        result.level_changed = rep != last_reg;
        result.confidence    = conf_reg;
        result.anomaly_level = anom_reg;
        result.modality_mask = weak_reg;
        result.strong_count  = sn_reg;
        result.denied_seen   = denied_reg != 4'd0;
    end

endmodule

@@ hw/rtl/presence_fusion_scorer_core.sv @@
`timescale 1ns / 1ps
// Presence fusion scorer. An observe item yields no result. An evaluate item
// runs from acceptance to a loaded result thus: the controller walks the nine
// channel slots, a scan and an accumulate state each, through one shared
// weight-by-quality multiplier, then scores, debounces and reports. The result
// sits in an output register, so the next item can be accepted while it waits.
module presence_fusion_scorer_core
    import pfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  pfs_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output pfs_out_t    out_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    pfs_cmd_t cmd;
    pfs_out_t result;
    logic     out_load, in_fire, out_valid_reg;
    pfs_out_t out_data_reg;

    assign in_fire = in_valid && in_ready;

    pfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_mode  (in_data.mode),
        .out_busy (out_valid_reg && !out_ready),
        .in_ready (in_ready),
        .out_load (out_load),
        .cmd      (cmd)
    );

    pfs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_data),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
